>>> rtl/isbl_pkg.sv
// ----------------------------------------------------------------------------
// isbl_pkg
// Shared types, constants and helpers for the IMU scale/bias/low-pass block.
// ----------------------------------------------------------------------------
package isbl_pkg;

    localparam int S_DATA_W = 176;
    localparam int M_DATA_W = 288;
    localparam int NUM_RAW  = 7;
    localparam int NUM_AXES = 6;

    localparam logic [2:0] TEMP_IDX   = 3'd6;
    localparam logic [2:0] LAST_AXIS  = 3'd5;
    localparam logic [2:0] FIRST_GYRO = 3'd3;

    localparam logic [2:0] CFG_ACCEL_SCALE  = 3'd0;
    localparam logic [2:0] CFG_GYRO_SCALE   = 3'd1;
    localparam logic [2:0] CFG_ACCEL_BIASES = 3'd2;
    localparam logic [2:0] CFG_GYRO_BIASES  = 3'd3;
    localparam logic [2:0] CFG_SMOOTHING    = 3'd4;

    localparam logic [23:0] ACCEL_SCALE_RST = 24'd10042;
    localparam logic [23:0] GYRO_SCALE_RST  = 24'd2234;
    localparam logic [16:0] ALPHA_ONE       = 17'd65536;

    // floor(n / 33) = (n * RECIP_33) >> 37 for 0 <= n < 2^31
    localparam logic [31:0]        RECIP_33       = 32'd4164816772;
    localparam logic signed [16:0] TEMP_ZERO_OFS  = 17'sd3300;
    localparam logic signed [32:0] TEMP_NUM_BIAS  = 33'sd1107296256;
    localparam logic signed [32:0] TEMP_HALF      = 33'sd16;
    localparam logic signed [27:0] TEMP_Q_BIAS    = 28'sd33554432;
    localparam logic signed [27:0] TEMP_MAX       = 28'sd16777215;
    localparam logic signed [27:0] TEMP_MIN       = -28'sd16777216;

    typedef enum logic [1:0] {
        OP_SCALE,
        OP_FILT,
        OP_TEMP
    } mul_op_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        mul_op_t    op;
        logic       scale_fix;
        logic       filt_fix;
        logic       temp_fix;
        logic       out_load;
        logic [2:0] axis;
    } isbl_cmd_t;

    typedef struct packed {
        logic out_free;
    } isbl_stat_t;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -52'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/isbl_ctrl.sv
// ----------------------------------------------------------------------------
// isbl_ctrl
// Sequencer: steps the shared multiplier through six axes and temperature.
// ----------------------------------------------------------------------------
module isbl_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  isbl_pkg::isbl_stat_t stat,
    output isbl_pkg::isbl_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCALE_MUL,
        S_SCALE_FIX,
        S_FILT_MUL,
        S_FILT_FIX,
        S_TEMP_MUL,
        S_TEMP_FIX,
        S_DONE
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] axis_reg;
    logic [2:0] axis_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_SCALE_MUL;
                    axis_next  = 3'd0;
                end
            end
            S_SCALE_MUL: state_next = S_SCALE_FIX;
            S_SCALE_FIX: state_next = S_FILT_MUL;
            S_FILT_MUL:  state_next = S_FILT_FIX;
            S_FILT_FIX:
            begin
                if (axis_reg == isbl_pkg::LAST_AXIS)
                begin
                    state_next = S_TEMP_MUL;
                end
                else
                begin
                    state_next = S_SCALE_MUL;
                    axis_next  = axis_reg + 3'd1;
                end
            end
            S_TEMP_MUL:  state_next = S_TEMP_FIX;
            S_TEMP_FIX:  state_next = S_DONE;
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    always_comb
    begin
        s_tready      = (state_reg == S_IDLE);
        cmd.load      = (state_reg == S_IDLE) && s_tvalid;
        cmd.mul_en    = (state_reg == S_SCALE_MUL) || (state_reg == S_FILT_MUL) ||
                        (state_reg == S_TEMP_MUL);
        cmd.op        = (state_reg == S_FILT_MUL) ? isbl_pkg::OP_FILT :
                        (state_reg == S_TEMP_MUL) ? isbl_pkg::OP_TEMP :
                                                    isbl_pkg::OP_SCALE;
        cmd.scale_fix = (state_reg == S_SCALE_FIX);
        cmd.filt_fix  = (state_reg == S_FILT_FIX);
        cmd.temp_fix  = (state_reg == S_TEMP_FIX);
        cmd.out_load  = (state_reg == S_DONE) && stat.out_free;
        cmd.axis      = axis_reg;
    end

endmodule

>>> rtl/isbl_dp.sv
// ----------------------------------------------------------------------------
// isbl_dp
// Datapath: config registers, sample capture, shared multiplier, filter state
// and the output register.
// ----------------------------------------------------------------------------
module isbl_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  isbl_pkg::isbl_cmd_t               cmd,
    output isbl_pkg::isbl_stat_t              stat,
    input  logic [isbl_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [2:0]                        cfg_index,
    input  logic [59:0]                       cfg_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [isbl_pkg::M_DATA_W-1:0]     m_tdata
);

    logic signed [15:0] raw_reg [isbl_pkg::NUM_RAW];
    logic [63:0]        stamp_reg;
    logic [23:0]        accel_scale_reg;
    logic [23:0]        gyro_scale_reg;
    logic [59:0]        accel_bias_reg;
    logic [59:0]        gyro_bias_reg;
    logic [16:0]        smoothing_reg;
    logic signed [31:0] filt_reg [isbl_pkg::NUM_AXES];
    logic signed [31:0] x_reg;
    logic signed [24:0] temp_reg;
    logic signed [66:0] prod_reg;
    logic               seeded_reg;
    logic               m_tvalid_reg;
    logic [isbl_pkg::M_DATA_W-1:0] m_tdata_reg;

    logic               is_gyro;
    logic [2:0]         bias_sel_idx;
    logic signed [15:0] raw_sel;
    logic [23:0]        scale_sel;
    logic [59:0]        bias_pack;
    logic signed [19:0] bias_sel;
    logic signed [31:0] prev_sel;
    logic [16:0]        alpha;
    logic signed [33:0] diff;
    logic signed [16:0] temp_t;
    logic signed [32:0] temp_num;
    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [41:0] scale_rnd;
    logic signed [33:0] scale_q16;
    logic signed [34:0] scale_biased;
    logic signed [31:0] x_next;
    logic signed [51:0] filt_rnd;
    logic signed [35:0] filt_delta;
    logic signed [51:0] filt_sum;
    logic signed [31:0] y_next;
    logic signed [27:0] temp_q;
    logic signed [24:0] temp_next;

    assign cfg_ready     = 1'b1;
    assign stat.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

    always_comb
    begin
        is_gyro      = (cmd.axis >= isbl_pkg::FIRST_GYRO);
        bias_sel_idx = is_gyro ? (cmd.axis - isbl_pkg::FIRST_GYRO) : cmd.axis;
        raw_sel      = raw_reg[cmd.axis];
        scale_sel    = is_gyro ? gyro_scale_reg : accel_scale_reg;
        bias_pack    = is_gyro ? gyro_bias_reg : accel_bias_reg;
        unique case (bias_sel_idx)
            3'd0:    bias_sel = bias_pack[19:0];
            3'd1:    bias_sel = bias_pack[39:20];
            default: bias_sel = bias_pack[59:40];
        endcase
        prev_sel = filt_reg[cmd.axis];
        alpha    = (smoothing_reg > isbl_pkg::ALPHA_ONE) ? isbl_pkg::ALPHA_ONE
                                                         : smoothing_reg;
        diff     = {{2{prev_sel[31]}}, prev_sel} - {{2{x_reg[31]}}, x_reg};
        temp_t   = {raw_reg[isbl_pkg::TEMP_IDX][15], raw_reg[isbl_pkg::TEMP_IDX]}
                   + isbl_pkg::TEMP_ZERO_OFS;
        temp_num = {{2{temp_t[16]}}, temp_t, 14'b0} + isbl_pkg::TEMP_HALF
                   + isbl_pkg::TEMP_NUM_BIAS;

        unique case (cmd.op)
            isbl_pkg::OP_FILT:
            begin
                mul_a = diff;
                mul_b = {16'b0, alpha};
            end
            isbl_pkg::OP_TEMP:
            begin
                mul_a = {1'b0, temp_num};
                mul_b = {1'b0, isbl_pkg::RECIP_33};
            end
            default:
            begin
                mul_a = {{18{raw_sel[15]}}, raw_sel};
                mul_b = {9'b0, scale_sel};
            end
        endcase

        scale_rnd    = prod_reg[41:0] + 42'sd128;
        scale_q16    = scale_rnd[41:8];
        scale_biased = {scale_q16[33], scale_q16} - {{15{bias_sel[19]}}, bias_sel};
        x_next       = isbl_pkg::sat32({{17{scale_biased[34]}}, scale_biased});

        filt_rnd     = prod_reg[51:0] + 52'sd32768;
        filt_delta   = filt_rnd[51:16];
        filt_sum     = {{20{x_reg[31]}}, x_reg} + {{16{filt_delta[35]}}, filt_delta};
        y_next       = seeded_reg ? isbl_pkg::sat32(filt_sum) : x_reg;

        temp_q       = {1'b0, prod_reg[63:37]} - isbl_pkg::TEMP_Q_BIAS;
        if (temp_q > isbl_pkg::TEMP_MAX)
        begin
            temp_next = isbl_pkg::TEMP_MAX[24:0];
        end
        else if (temp_q < isbl_pkg::TEMP_MIN)
        begin
            temp_next = isbl_pkg::TEMP_MIN[24:0];
        end
        else
        begin
            temp_next = temp_q[24:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_scale_reg <= isbl_pkg::ACCEL_SCALE_RST;
            gyro_scale_reg  <= isbl_pkg::GYRO_SCALE_RST;
            accel_bias_reg  <= '0;
            gyro_bias_reg   <= '0;
            smoothing_reg   <= '0;
            seeded_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    isbl_pkg::CFG_ACCEL_SCALE:  accel_scale_reg <= cfg_data[23:0];
                    isbl_pkg::CFG_GYRO_SCALE:   gyro_scale_reg  <= cfg_data[23:0];
                    isbl_pkg::CFG_ACCEL_BIASES: accel_bias_reg  <= cfg_data;
                    isbl_pkg::CFG_GYRO_BIASES:  gyro_bias_reg   <= cfg_data;
                    isbl_pkg::CFG_SMOOTHING:    smoothing_reg   <= cfg_data[16:0];
                    default:                    ;
                endcase
            end
            if (cmd.out_load)
            begin
                seeded_reg   <= 1'b1;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            for (int i = 0; i < isbl_pkg::NUM_RAW; i++)
            begin
                raw_reg[i] <= s_tdata[16*i +: 16];
            end
            stamp_reg <= s_tdata[175:112];
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.scale_fix)
        begin
            x_reg <= x_next;
        end
        if (cmd.filt_fix)
        begin
            filt_reg[cmd.axis] <= y_next;
        end
        if (cmd.temp_fix)
        begin
            temp_reg <= temp_next;
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {7'b0, stamp_reg, temp_reg, filt_reg[5], filt_reg[4],
                            filt_reg[3], filt_reg[2], filt_reg[1], filt_reg[0]};
        end
    end

endmodule

>>> rtl/imu_scale_bias_lowpass.sv
// ----------------------------------------------------------------------------
// imu_scale_bias_lowpass
// IMU sample conditioning: per-axis scale and bias, exponential low-pass on
// six axes, temperature conversion and timestamp pass-through.
//
// Usage:
//   s_* carries one raw sample per beat; m_* carries one conditioned result
//   per beat. cfg_* writes one register per beat (index 0..4, others are
//   ignored) and is always ready; write only while no sample is in flight.
//   A single multiplier is sequenced over scale, filter and temperature
//   steps: a scale multiply and fix, then a filter multiply and fix per
//   axis, then a temperature multiply and fix. A new sample is accepted
//   only after the previous result is loaded into the output register.
//   The output register holds a finished result, so the next sample is taken
//   and worked on while the receiver stalls; the sequencer waits at its last
//   step only if the previous result is still unclaimed.
//   Reset restores register defaults and clears the filter seed, so the first
//   sample after reset passes unfiltered.
// ----------------------------------------------------------------------------
module imu_scale_bias_lowpass (
    input  logic                          clk,
    input  logic                          rst_n,
    // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw,
    // gyro_z_raw, temp_raw (16 each), stamp_in (64)
    input  logic [isbl_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // accel_x_out, accel_y_out, accel_z_out, gyro_x_out, gyro_y_out,
    // gyro_z_out (32 each), temp_out (25), stamp_out (64), 7 zero bits
    output logic [isbl_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [59:0]                   cfg_data
);

    isbl_pkg::isbl_cmd_t  cmd;
    isbl_pkg::isbl_stat_t stat;

    isbl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    isbl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    a_no_back_to_back_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a sample is in flight");

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!m_tvalid || m_tready))
        else $error("result loaded over an unclaimed result");

    a_out_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> m_tvalid)
        else $error("loaded result not presented");

    a_single_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.mul_en, cmd.scale_fix, cmd.filt_fix,
                  cmd.temp_fix, cmd.out_load}))
        else $error("more than one datapath step commanded");

endmodule
